>>> src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> src/rcd_pkg.sv
// Shared constants and types of the repetition code decoder.
// Used by every module of the block but rcd_ram; depends on nothing.
package rcd_pkg;

  localparam int MaxMessage = 1024;
  localparam int MaxReps    = 16;

  localparam int LlrW     = 8;
  localparam int PosW     = 10;
  localparam int RepW     = 4;
  localparam int SumW     = 13;
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 2;
  localparam int LenW     = 11;
  localparam int CountW   = 5;

  localparam logic [CfgIdxW-1:0] RegMessageLength   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRepetitionCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDecisionMode    = 2'd2;

  localparam logic ModeHard = 1'b0;
  localparam logic ModeSoft = 1'b1;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            first_rep;
    logic            is_final;
    logic            last_pos;
  } item_t;

  typedef struct packed {
    logic mode;
    logic restart;
  } cfg_t;

endpackage

>>> src/rcd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module rcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rcd_ctrl.sv
// Configuration registers and frame position counters of the decoder.
// Depends on rcd_pkg.
module rcd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          accept_i,
  output rcd_pkg::item_t                item_o,
  output rcd_pkg::cfg_t                 cfg_o
);

  logic [rcd_pkg::PosW-1:0] msg_last_q, msg_last_d;
  logic [rcd_pkg::RepW-1:0] rep_last_q, rep_last_d;
  logic                     mode_q, mode_d;
  logic [rcd_pkg::PosW-1:0] pos_q, pos_d;
  logic [rcd_pkg::RepW-1:0] rep_q, rep_d;

  logic [rcd_pkg::LenW-1:0]   len_val;
  logic [rcd_pkg::LenW-1:0]   len_m1;
  logic [rcd_pkg::CountW-1:0] cnt_val;
  logic [rcd_pkg::CountW-1:0] cnt_m1;

  assign len_val = cfg_data_i[rcd_pkg::LenW-1:0];
  assign len_m1  = len_val - rcd_pkg::LenW'(1);
  assign cnt_val = cfg_data_i[rcd_pkg::CountW-1:0];
  assign cnt_m1  = cnt_val - rcd_pkg::CountW'(1);

  always_comb begin
    msg_last_d = msg_last_q;
    rep_last_d = rep_last_q;
    mode_d     = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        rcd_pkg::RegMessageLength: begin
          if (len_val == '0) begin
            msg_last_d = '0;
          end else if (len_val > rcd_pkg::LenW'(rcd_pkg::MaxMessage)) begin
            msg_last_d = rcd_pkg::PosW'(rcd_pkg::MaxMessage - 1);
          end else begin
            msg_last_d = len_m1[rcd_pkg::PosW-1:0];
          end
        end
        rcd_pkg::RegRepetitionCount: begin
          if (cnt_val == '0) begin
            rep_last_d = '0;
          end else if (cnt_val > rcd_pkg::CountW'(rcd_pkg::MaxReps)) begin
            rep_last_d = rcd_pkg::RepW'(rcd_pkg::MaxReps - 1);
          end else begin
            rep_last_d = cnt_m1[rcd_pkg::RepW-1:0];
          end
        end
        rcd_pkg::RegDecisionMode: begin
          mode_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pos_d = pos_q;
    rep_d = rep_q;
    if (cfg_we_i) begin
      pos_d = '0;
      rep_d = '0;
    end else if (accept_i) begin
      if (pos_q == msg_last_q) begin
        pos_d = '0;
        rep_d = (rep_q == rep_last_q) ? '0 : rep_q + rcd_pkg::RepW'(1);
      end else begin
        pos_d = pos_q + rcd_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_last_q <= rcd_pkg::PosW'(15);
      rep_last_q <= rcd_pkg::RepW'(2);
      mode_q     <= rcd_pkg::ModeHard;
      pos_q      <= '0;
      rep_q      <= '0;
    end else begin
      msg_last_q <= msg_last_d;
      rep_last_q <= rep_last_d;
      mode_q     <= mode_d;
      pos_q      <= pos_d;
      rep_q      <= rep_d;
    end
  end

  assign item_o.pos       = pos_q;
  assign item_o.first_rep = (rep_q == '0);
  assign item_o.is_final  = (rep_q == rep_last_q);
  assign item_o.last_pos  = (pos_q == msg_last_q);
  assign cfg_o.mode       = mode_q;
  assign cfg_o.restart    = cfg_we_i;

endmodule

>>> src/rcd_acc.sv
// Accumulate stage, bit decision and result register of the decoder.
// Depends on rcd_pkg; reads and writes the sum RAM through its ports.
module rcd_acc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [rcd_pkg::LlrW-1:0] llr_i,
  input  rcd_pkg::item_t             item_i,
  input  rcd_pkg::cfg_t              cfg_i,
  input  logic [rcd_pkg::SumW-1:0]   rdata_i,
  output logic                       we_o,
  output logic [rcd_pkg::PosW-1:0]   waddr_o,
  output logic [rcd_pkg::SumW-1:0]   wdata_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       decoded_bit_o,
  output logic [rcd_pkg::PosW-1:0]   bit_index_o,
  output logic                       last_bit_o
);

  logic                      s1_valid_q, s1_valid_d;
  rcd_pkg::item_t            s1_item_q;
  logic [rcd_pkg::LlrW-1:0]  s1_llr_q;
  logic                      fwd_hit_q;
  logic [rcd_pkg::SumW-1:0]  fwd_sum_q;
  logic                      tie_q, tie_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_bit_q;
  logic [rcd_pkg::PosW-1:0]  out_idx_q;
  logic                      out_last_q;

  logic                      accept;
  logic                      s1_fire;
  logic                      out_load;
  logic [rcd_pkg::SumW-1:0]  contrib;
  logic [rcd_pkg::SumW-1:0]  base;
  logic [rcd_pkg::SumW-1:0]  sum;
  logic                      sum_zero;
  logic                      tie_used;
  logic                      bit_val;

  assign s1_fire    = s1_valid_q && (!s1_item_q.is_final || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = s1_fire && s1_item_q.is_final;

  always_comb begin
    if (cfg_i.mode == rcd_pkg::ModeSoft) begin
      contrib = {{(rcd_pkg::SumW - rcd_pkg::LlrW){s1_llr_q[rcd_pkg::LlrW-1]}}, s1_llr_q};
    end else if (s1_llr_q[rcd_pkg::LlrW-1]) begin
      contrib = '1;
    end else begin
      contrib = rcd_pkg::SumW'(1);
    end
  end

  always_comb begin
    if (s1_item_q.first_rep) begin
      base = '0;
    end else if (fwd_hit_q) begin
      base = fwd_sum_q;
    end else begin
      base = rdata_i;
    end
  end

  assign sum      = base + contrib;
  assign sum_zero = (sum == '0);
  assign tie_used = sum_zero && (cfg_i.mode == rcd_pkg::ModeHard);

  always_comb begin
    if (sum[rcd_pkg::SumW-1]) begin
      bit_val = 1'b1;
    end else if (tie_used) begin
      bit_val = tie_q;
    end else begin
      bit_val = 1'b0;
    end
  end

  always_comb begin
    tie_d = tie_q;
    if (cfg_i.restart) begin
      tie_d = 1'b0;
    end else if (out_load) begin
      if (s1_item_q.last_pos) begin
        tie_d = 1'b0;
      end else if (tie_used) begin
        tie_d = ~tie_q;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      tie_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      tie_q       <= tie_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        fwd_hit_q <= s1_fire && (item_i.pos == s1_item_q.pos);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
      s1_llr_q  <= llr_i;
    end
    if (s1_fire) begin
      fwd_sum_q <= sum;
    end
    if (out_load) begin
      out_bit_q  <= bit_val;
      out_idx_q  <= s1_item_q.pos;
      out_last_q <= s1_item_q.last_pos;
    end
  end

  assign we_o          = s1_fire;
  assign waddr_o       = s1_item_q.pos;
  assign wdata_o       = sum;
  assign out_valid_o   = out_valid_q;
  assign decoded_bit_o = out_bit_q;
  assign bit_index_o   = out_idx_q;
  assign last_bit_o    = out_last_q;

endmodule

>>> src/repetition_code_decoder.sv
// Top level of the repetition code decoder: counters, sum RAM and accumulate stage.
// Depends on rcd_pkg, rcd_ctrl, rcd_ram and rcd_acc.
//
//   Channel   Direction  Handshake                Word
//   input     in         in_valid_i / in_ready_o  llr_i
//   result    out        out_valid_o / out_ready_i decoded_bit_o, bit_index_o, last_bit_o
//   config    in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while in_ready_o is high. The sum RAM read is issued at
// acceptance; add and write-back follow in the stage, which passes final-copy words on
// to the result register. A register forwards the sum to consecutive same-index words.
// Reset is asynchronous; the sum RAM needs no clearing pass, as the first copy writes it.
// Input stalls only when a final-copy word waits in the stage behind a full result
// register that out_ready_i does not drain in that cycle.
module repetition_code_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rcd_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [rcd_pkg::LlrW-1:0]   llr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              decoded_bit_o,
  output logic [rcd_pkg::PosW-1:0]          bit_index_o,
  output logic                              last_bit_o
);

  rcd_pkg::item_t           item;
  rcd_pkg::cfg_t            cfg;
  logic                     accept;
  logic                     ram_we;
  logic [rcd_pkg::PosW-1:0] ram_waddr;
  logic [rcd_pkg::SumW-1:0] ram_wdata;
  logic [rcd_pkg::SumW-1:0] ram_rdata;

  assign accept = in_valid_i && in_ready_o;

  rcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_o      (item),
    .cfg_o       (cfg)
  );

  rcd_ram #(
    .Width (rcd_pkg::SumW),
    .Depth (rcd_pkg::MaxMessage)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (item.pos),
    .rdata_o (ram_rdata)
  );

  rcd_acc u_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .llr_i         (llr_i),
    .item_i        (item),
    .cfg_i         (cfg),
    .rdata_i       (ram_rdata),
    .we_o          (ram_we),
    .waddr_o       (ram_waddr),
    .wdata_o       (ram_wdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .decoded_bit_o (decoded_bit_o),
    .bit_index_o   (bit_index_o),
    .last_bit_o    (last_bit_o)
  );

endmodule

>>> src/rcd_check.sv
// Port-level checks of the repetition code decoder, bound to the top level.
// Depends on rcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcd_check (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              decoded_bit_o,
  input logic [rcd_pkg::PosW-1:0]          bit_index_o,
  input logic                              last_bit_o
);

  logic [rcd_pkg::PosW-1:0] exp_idx_q;
  logic [rcd_pkg::PosW+1:0] out_word;

  assign out_word = {decoded_bit_o, bit_index_o, last_bit_o};

  // Results of a frame come out in index order, and a frame's last result wraps to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (cfg_we_i) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_idx_q <= last_bit_o ? '0 : bit_index_o + rcd_pkg::PosW'(1);
    end
  end

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))
  `ASSERT_IMPL(a_idx_order, out_valid_o, bit_index_o == exp_idx_q)
  `ASSERT_IMPL(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind repetition_code_decoder rcd_check u_rcd_check (.*);
